// ===== design/id_interval_set_table_core_macros.svh =====
// Assertion helpers for the interval set table.
// Assertions expect clk and arst_n in scope.
`ifndef ID_INTERVAL_SET_TABLE_CORE_MACROS_SVH
`define ID_INTERVAL_SET_TABLE_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define IDST_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: same-cycle check failed");
`define IDST_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: next-cycle check failed");
`else
`define IDST_ASSERT_IMP(lbl, ante, cons)
`define IDST_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== design/idst_pkg.sv =====
package idst_pkg;

	localparam int MAX_INTERVALS = 64;
	localparam int ID_BITS       = 31;
	localparam int IDX_W         = $clog2(MAX_INTERVALS);
	localparam int CNT_W         = IDX_W + 1;
	localparam int COUNT_W       = 32;
	localparam int ACT_W         = 2;

	localparam logic [ACT_W-1:0] ACT_QUERY  = 2'd0;
	localparam logic [ACT_W-1:0] ACT_INSERT = 2'd1;
	localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd2;
	// unused code, behaves as a query
	localparam logic [ACT_W-1:0] ACT_SPARE  = 2'd3;

	// one table entry: closed interval [first, last]
	typedef struct packed {
		logic [ID_BITS-1:0] first;
		logic [ID_BITS-1:0] last;
	} idst_ent_t;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic scan;
		logic plan;
		logic shift;
		logic wr0;
		logic wr1;
	} idst_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic scan_done;
		logic shift_done;
	} idst_sts_t;

endpackage

// ===== design/idst_req_if.sv =====
interface idst_req_if import idst_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [ACT_W-1:0]   action;
	logic [ID_BITS-1:0] member_id;

	modport source (output valid, output action, output member_id, input ready);
	modport sink (input valid, input action, input member_id, output ready);
endinterface

// ===== design/idst_rsp_if.sv =====
interface idst_rsp_if import idst_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               was_present;
	logic [COUNT_W-1:0] member_count;
	logic [CNT_W-1:0]   intervals_used;
	logic               status;

	modport source (output valid, output was_present, output member_count,
		output intervals_used, output status, input ready);
	modport sink (input valid, input was_present, input member_count,
		input intervals_used, input status, output ready);
endinterface

// ===== design/idst_ctrl.sv =====
module idst_ctrl import idst_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  idst_sts_t sts,
	output idst_cmd_t cmd
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SCAN  = 3'd1;
	localparam logic [2:0] ST_PLAN  = 3'd2;
	localparam logic [2:0] ST_SHIFT = 3'd3;
	localparam logic [2:0] ST_WR0   = 3'd4;
	localparam logic [2:0] ST_WR1   = 3'd5;
	localparam logic [2:0] ST_RESP  = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_RESP);

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_done) state_d = ST_PLAN;
			end
			ST_PLAN: begin
				cmd.plan = 1'b1;
				state_d  = ST_SHIFT;
			end
			ST_SHIFT: begin
				cmd.shift = 1'b1;
				if (sts.shift_done) state_d = ST_WR0;
			end
			ST_WR0: begin
				cmd.wr0 = 1'b1;
				state_d = ST_WR1;
			end
			ST_WR1: begin
				cmd.wr1 = 1'b1;
				state_d = ST_RESP;
			end
			ST_RESP: begin
				if (out_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

endmodule

// ===== design/idst_dp.sv =====
module idst_dp import idst_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [ACT_W-1:0]   in_action,
	input  logic [ID_BITS-1:0] in_id,
	input  idst_cmd_t          cmd,
	output idst_sts_t          sts,
	output logic               was_present,
	output logic [COUNT_W-1:0] member_count,
	output logic [CNT_W-1:0]   intervals_used,
	output logic               status
);

	localparam logic [1:0] SH_NONE = 2'd0;
	localparam logic [1:0] SH_DOWN = 2'd1;
	localparam logic [1:0] SH_UP   = 2'd2;

	// table memory, one read port and one write port, registered read
	idst_ent_t mem [MAX_INTERVALS];
	idst_ent_t rd_s1;

	// request and set state
	logic [ACT_W-1:0]   act_q;
	logic [ID_BITS-1:0] id_q;
	logic [CNT_W-1:0]   total_q;
	logic [COUNT_W-1:0] count_q;

	// scan / shift engine
	logic [CNT_W-1:0] ptr_q;
	logic             rvalid_s1;
	logic [CNT_W-1:0] pos_q;
	logic             found_q;
	idst_ent_t        prev_q;
	idst_ent_t        nxt_q;
	logic             wp_s1;
	logic [IDX_W-1:0] wa_s1;

	// latched plan
	logic [1:0]         dir_q;
	logic [CNT_W-1:0]   lo_q;
	logic               w0_en_q, w1_en_q;
	logic [IDX_W-1:0]   w0_a_q, w1_a_q;
	idst_ent_t          w0_d_q, w1_d_q;
	logic [CNT_W-1:0]   ntot_q;
	logic [COUNT_W-1:0] ncnt_q;
	logic               present_q;
	logic               status_q;

	// plan terms
	logic               p_present, p_left, p_right, p_full;
	logic [CNT_W-1:0]   pm1, pp1;
	logic [1:0]         p_dir;
	logic [CNT_W-1:0]   p_lo;
	logic               p_w0_en, p_w1_en;
	logic [IDX_W-1:0]   p_w0_a, p_w1_a;
	idst_ent_t          p_w0_d, p_w1_d;
	logic [CNT_W-1:0]   p_ntot;
	logic [COUNT_W-1:0] p_ncnt;
	logic               p_status;
	logic [ID_BITS-1:0] id_inc, id_dec;

	logic             found_now, scan_issue, sh_issue;
	logic [CNT_W-1:0] ptr_dec;
	logic [IDX_W-1:0] raddr;
	logic             we;
	logic [IDX_W-1:0] wa;
	idst_ent_t        wd;

	// scan compare: first entry that starts above the id
	assign found_now  = rvalid_s1 && (rd_s1.first > id_q);
	assign scan_issue = (ptr_q < total_q);
	assign sts.scan_done = found_now || (!rvalid_s1 && !scan_issue);

	// shift pointer walks up for a close, down for an open
	assign ptr_dec  = ptr_q - 1'b1;
	assign sh_issue = ((dir_q == SH_DOWN) && (ptr_q < total_q)) ||
		((dir_q == SH_UP) && (ptr_q > lo_q));
	assign sts.shift_done = !sh_issue && !wp_s1;

	assign raddr = (cmd.shift && (dir_q == SH_UP)) ? ptr_dec[IDX_W-1:0] : ptr_q[IDX_W-1:0];

	// write port select
	always_comb begin
		we = 1'b0;
		wa = wa_s1;
		wd = rd_s1;
		if (cmd.shift && wp_s1) begin
			we = 1'b1;
		end else if (cmd.wr0 && w0_en_q) begin
			we = 1'b1;
			wa = w0_a_q;
			wd = w0_d_q;
		end else if (cmd.wr1 && w1_en_q) begin
			we = 1'b1;
			wa = w1_a_q;
			wd = w1_d_q;
		end
	end

	always_ff @(posedge clk) begin
		if (we) mem[wa] <= wd;
		rd_s1 <= mem[raddr];
	end

	// decide the edit from the scan result
	assign id_inc = id_q + 1'b1;
	assign id_dec = id_q - 1'b1;
	assign pm1    = pos_q - 1'b1;
	assign pp1    = pos_q + 1'b1;

	always_comb begin
		p_present = (pos_q != '0) && (prev_q.last >= id_q);
		p_left    = (pos_q != '0) && (ID_BITS'(prev_q.last + 1'b1) == id_q);
		p_right   = found_q && (id_inc == nxt_q.first);
		p_full    = (total_q == CNT_W'(MAX_INTERVALS));
		p_dir     = SH_NONE;
		p_lo      = pos_q;
		p_w0_en   = 1'b0;
		p_w0_a    = pm1[IDX_W-1:0];
		p_w0_d    = prev_q;
		p_w1_en   = 1'b0;
		p_w1_a    = pos_q[IDX_W-1:0];
		p_w1_d    = prev_q;
		p_ntot    = total_q;
		p_ncnt    = count_q;
		p_status  = 1'b0;
		if ((act_q == ACT_INSERT) && !p_present) begin
			if (p_left && p_right) begin
				// bridge: join the two neighbors, close the right slot
				p_w0_en = 1'b1;
				p_w0_d  = '{first: prev_q.first, last: nxt_q.last};
				p_dir   = SH_DOWN;
				p_lo    = pp1;
				p_ntot  = total_q - 1'b1;
				p_ncnt  = count_q + 1'b1;
			end else if (p_left) begin
				p_w0_en = 1'b1;
				p_w0_d  = '{first: prev_q.first, last: id_q};
				p_ncnt  = count_q + 1'b1;
			end else if (p_right) begin
				p_w0_en = 1'b1;
				p_w0_a  = pos_q[IDX_W-1:0];
				p_w0_d  = '{first: id_q, last: nxt_q.last};
				p_ncnt  = count_q + 1'b1;
			end else if (!p_full) begin
				p_dir   = SH_UP;
				p_w0_en = 1'b1;
				p_w0_a  = pos_q[IDX_W-1:0];
				p_w0_d  = '{first: id_q, last: id_q};
				p_ntot  = total_q + 1'b1;
				p_ncnt  = count_q + 1'b1;
			end else begin
				p_status = 1'b1;
			end
		end else if ((act_q == ACT_REMOVE) && p_present) begin
			if (id_q == prev_q.first) begin
				if (prev_q.first < prev_q.last) begin
					p_w0_en = 1'b1;
					p_w0_d  = '{first: id_inc, last: prev_q.last};
				end else begin
					// single-id interval goes away
					p_dir  = SH_DOWN;
					p_ntot = total_q - 1'b1;
				end
				p_ncnt = count_q - 1'b1;
			end else if (id_q == prev_q.last) begin
				p_w0_en = 1'b1;
				p_w0_d  = '{first: prev_q.first, last: id_dec};
				p_ncnt  = count_q - 1'b1;
			end else if (!p_full) begin
				// split into two pieces
				p_dir   = SH_UP;
				p_w0_en = 1'b1;
				p_w0_d  = '{first: prev_q.first, last: id_dec};
				p_w1_en = 1'b1;
				p_w1_d  = '{first: id_inc, last: prev_q.last};
				p_ntot  = total_q + 1'b1;
				p_ncnt  = count_q - 1'b1;
			end else begin
				p_status = 1'b1;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q <= in_action;
			id_q  <= in_id;
		end
		if (cmd.scan && rvalid_s1) begin
			if (found_now) nxt_q <= rd_s1;
			else prev_q <= rd_s1;
		end
		if (cmd.plan) begin
			lo_q      <= p_lo;
			w0_en_q   <= p_w0_en;
			w0_a_q    <= p_w0_a;
			w0_d_q    <= p_w0_d;
			w1_en_q   <= p_w1_en;
			w1_a_q    <= p_w1_a;
			w1_d_q    <= p_w1_d;
			ntot_q    <= p_ntot;
			ncnt_q    <= p_ncnt;
			present_q <= p_present;
			status_q  <= p_status;
		end
		wa_s1 <= (dir_q == SH_DOWN) ? ptr_dec[IDX_W-1:0] : ptr_q[IDX_W-1:0];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q   <= '0;
			count_q   <= '0;
			ptr_q     <= '0;
			rvalid_s1 <= 1'b0;
			pos_q     <= '0;
			found_q   <= 1'b0;
			dir_q     <= SH_NONE;
			wp_s1     <= 1'b0;
		end else begin
			wp_s1 <= cmd.shift && sh_issue;
			if (cmd.load) begin
				ptr_q     <= '0;
				rvalid_s1 <= 1'b0;
				pos_q     <= '0;
				found_q   <= 1'b0;
			end else if (cmd.scan) begin
				rvalid_s1 <= scan_issue;
				if (scan_issue) ptr_q <= ptr_q + 1'b1;
				if (rvalid_s1) begin
					if (found_now) found_q <= 1'b1;
					else pos_q <= ptr_q;
				end
			end else if (cmd.plan) begin
				dir_q <= p_dir;
				ptr_q <= (p_dir == SH_DOWN) ? p_lo : total_q;
			end else if (cmd.shift) begin
				if (sh_issue) begin
					if (dir_q == SH_DOWN) ptr_q <= ptr_q + 1'b1;
					else ptr_q <= ptr_dec;
				end
			end else if (cmd.wr1) begin
				total_q <= ntot_q;
				count_q <= ncnt_q;
			end
		end
	end

	assign was_present    = present_q;
	assign member_count   = count_q;
	assign intervals_used = total_q;
	assign status         = status_q;

endmodule

// ===== design/id_interval_set_table_core.sv =====
// Interval set table: keeps a set of 31-bit IDs as up to 64 sorted, disjoint
// closed intervals and answers query, insert and remove requests, one result
// per request. One request is in flight at a time. The scan reads the
// table memory one entry per cycle until it passes the ID, and an
// insert or removal that opens or closes a slot moves every later entry once
// through the table memory. The scan stops where the moves begin, so scanned
// plus moved entries stay within the table size plus one. When a new interval
// is needed and all 64 are in use, the request is dropped and status reads 1.
// The table needs no clearing after reset.
`include "id_interval_set_table_core_macros.svh"

module id_interval_set_table_core import idst_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	idst_req_if.sink   req,
	idst_rsp_if.source rsp
);

	idst_cmd_t cmd;
	idst_sts_t sts;

	idst_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	idst_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_action      (req.action),
		.in_id          (req.member_id),
		.cmd            (cmd),
		.sts            (sts),
		.was_present    (rsp.was_present),
		.member_count   (rsp.member_count),
		.intervals_used (rsp.intervals_used),
		.status         (rsp.status)
	);

	// table never holds more than its capacity
	`IDST_ASSERT_IMP(a_used_max, 1'b1, rsp.intervals_used <= CNT_W'(MAX_INTERVALS))
	// a dropped request only happens on a full table
	`IDST_ASSERT_IMP(a_full_drop, rsp.valid && rsp.status,
		rsp.intervals_used == CNT_W'(MAX_INTERVALS))
	// no new request while a result is pending
	`IDST_ASSERT_IMP(a_one_flight, rsp.valid, !req.ready)
	// a result never shows in the cycle after a request is taken
	`IDST_ASSERT_NXT(a_no_early, req.valid && req.ready, !rsp.valid)

endmodule

// ===== tb/sv/id_interval_set_table_core_tb.sv =====
`timescale 1ns / 100ps

module id_interval_set_table_core_tb;
	import idst_pkg::*;

	localparam int STALL_LIMIT = 20000;

	typedef struct {
		logic [ACT_W-1:0]   action;
		logic [ID_BITS-1:0] member_id;
		bit                 hold;
	} set_req_t;

	typedef struct {
		bit                 was_present;
		logic [COUNT_W-1:0] member_count;
		logic [CNT_W-1:0]   intervals_used;
		bit                 status;
	} set_rsp_t;

	logic clk;
	logic arst_n;

	idst_req_if req ();
	idst_rsp_if rsp ();

	id_interval_set_table_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req.sink),
		.rsp    (rsp.source)
	);

	// shadow copy of the interval table
	logic [ID_BITS-1:0] lo_tab [MAX_INTERVALS];
	logic [ID_BITS-1:0] hi_tab [MAX_INTERVALS];
	int                 run_cnt;
	logic [COUNT_W-1:0] pop_cnt;

	set_req_t pending_reqs[$];
	set_rsp_t expected_rsps[$];
	int       errors;
	int       gap_left;
	int       idle_cycles;
	bit       stim_done;
	bit       holding;

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 150);
	endfunction

	// slide entries up from index at, making room
	function automatic void table_open(int at);
		for (int k = run_cnt; k > at; k--) begin
			lo_tab[k] = lo_tab[k-1];
			hi_tab[k] = hi_tab[k-1];
		end
		run_cnt++;
	endfunction

	function automatic void table_close(int at);
		for (int k = at; k + 1 < run_cnt; k++) begin
			lo_tab[k] = lo_tab[k+1];
			hi_tab[k] = hi_tab[k+1];
		end
		run_cnt--;
	endfunction

	// apply one request to the shadow table and return the expected response
	function automatic set_rsp_t apply_request(logic [ACT_W-1:0] act, logic [ID_BITS-1:0] id);
		set_rsp_t r;
		int       pos;
		int       k;
		bit       hit;
		bit       join_lo;
		bit       join_hi;
		r.status = 0;
		pos = 0;
		while (pos < run_cnt && lo_tab[pos] <= id)
			pos++;
		hit = pos > 0 && hi_tab[pos-1] >= id;
		if (act == ACT_INSERT && !hit) begin
			join_lo = pos > 0 && {1'b0, hi_tab[pos-1]} + 1 == {1'b0, id};
			join_hi = pos < run_cnt && {1'b0, id} + 1 == {1'b0, lo_tab[pos]};
			if (join_lo && join_hi) begin
				hi_tab[pos-1] = hi_tab[pos];
				table_close(pos);
				pop_cnt++;
			end else if (join_lo) begin
				hi_tab[pos-1] = id;
				pop_cnt++;
			end else if (join_hi) begin
				lo_tab[pos] = id;
				pop_cnt++;
			end else if (run_cnt < MAX_INTERVALS) begin
				table_open(pos);
				lo_tab[pos] = id;
				hi_tab[pos] = id;
				pop_cnt++;
			end else begin
				r.status = 1;
			end
		end else if (act == ACT_REMOVE && hit) begin
			k = pos - 1;
			if (id == lo_tab[k]) begin
				if (lo_tab[k] < hi_tab[k])
					lo_tab[k] = ID_BITS'(id + 1'b1);
				else
					table_close(k);
				pop_cnt--;
			end else if (id == hi_tab[k]) begin
				hi_tab[k] = ID_BITS'(id - 1'b1);
				pop_cnt--;
			end else if (run_cnt < MAX_INTERVALS) begin
				table_open(k + 1);
				lo_tab[k+1] = ID_BITS'(id + 1'b1);
				hi_tab[k+1] = hi_tab[k];
				hi_tab[k] = ID_BITS'(id - 1'b1);
				pop_cnt--;
			end else begin
				r.status = 1;
			end
		end
		r.was_present = hit;
		r.member_count = pop_cnt;
		r.intervals_used = run_cnt[CNT_W-1:0];
		return r;
	endfunction

	task automatic add_req(logic [ACT_W-1:0] act, logic [ID_BITS-1:0] id, bit hold = 0);
		set_req_t q;
		q.action = act;
		q.member_id = id;
		q.hold = hold;
		pending_reqs.push_back(q);
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
			req.action <= ACT_QUERY;
			req.member_id <= '0;
			gap_left <= 0;
			holding <= 1'b0;
		end else begin
			automatic bit busy = req.valid && !req.ready;
			if (!busy) begin
				if (req.valid)
					expected_rsps.push_back(apply_request(req.action, req.member_id));
				if (holding && expected_rsps.size() == 0 && !(req.valid && req.ready))
					holding <= 1'b0;
				if (gap_left > 0 || holding || pending_reqs.size() == 0) begin
					req.valid <= 1'b0;
					if (gap_left > 0)
						gap_left <= gap_left - 1;
				end else if (pending_reqs[0].hold && !holding &&
						(expected_rsps.size() != 0 || req.valid)) begin
					req.valid <= 1'b0;
					holding <= 1'b1;
					pending_reqs[0].hold = 0;
				end else begin
					automatic set_req_t q = pending_reqs.pop_front();
					req.valid <= 1'b1;
					req.action <= q.action;
					req.member_id <= q.member_id;
					gap_left <= pick_gap();
				end
			end
		end
	end

	// response monitor and ready generation
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (expected_rsps.size() == 0) begin
					$display("%0t: unexpected response exp none act p=%0b c=%0d n=%0d s=%0b",
						$realtime, rsp.was_present, rsp.member_count,
						rsp.intervals_used, rsp.status);
					errors++;
				end else begin
					automatic set_rsp_t e = expected_rsps.pop_front();
					if (rsp.was_present !== e.was_present) begin
						$display("%0t: was_present exp %0b act %0b", $realtime,
							e.was_present, rsp.was_present);
						errors++;
					end
					if (rsp.member_count !== e.member_count) begin
						$display("%0t: member_count exp %0d act %0d", $realtime,
							e.member_count, rsp.member_count);
						errors++;
					end
					if (rsp.intervals_used !== e.intervals_used) begin
						$display("%0t: intervals_used exp %0d act %0d", $realtime,
							e.intervals_used, rsp.intervals_used);
						errors++;
					end
					if (rsp.status !== e.status) begin
						$display("%0t: status exp %0b act %0b", $realtime,
							e.status, rsp.status);
						errors++;
					end
				end
			end
			rsp.ready <= (pick_gap() == 0) || ($urandom_range(0, 1) == 1);
		end
	end

	// watchdog on accepted traffic
	always @(posedge clk) begin
		if (!arst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		logic [ID_BITS-1:0] base;
		logic [ID_BITS-1:0] id;
		int                 r;
		errors = 0;
		idle_cycles = 0;
		stim_done = 0;
		run_cnt = 0;
		pop_cnt = '0;
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.action = ACT_QUERY;
		req.member_id = '0;
		rsp.ready = 1'b0;

		// directed: field extremes, all actions, neighbor join, split, trim
		add_req(ACT_QUERY, '0);
		add_req(ACT_INSERT, '0);
		add_req(ACT_INSERT, '0);
		add_req(ACT_INSERT, '1);
		add_req(ACT_QUERY, '1);
		add_req(ACT_SPARE, '1);
		add_req(ACT_REMOVE, 31'd5);
		add_req(ACT_INSERT, 31'd2);
		add_req(ACT_INSERT, 31'd1);
		add_req(ACT_INSERT, 31'h7FFF_FFFE);
		add_req(ACT_INSERT, 31'd3);
		add_req(ACT_REMOVE, 31'd1);
		add_req(ACT_INSERT, 31'd1);
		add_req(ACT_REMOVE, 31'd3);
		add_req(ACT_REMOVE, 31'd0);
		add_req(ACT_REMOVE, '1);
		add_req(ACT_REMOVE, 31'h7FFF_FFFE);
		add_req(ACT_INSERT, 31'h5555_5555);
		add_req(ACT_REMOVE, 31'h5555_5555, 1);
		add_req(ACT_REMOVE, 31'h2AAA_AAAA);

		// random: IDs near a moving base so neighbors, joins and splits happen
		for (int i = 0; i < 1250; i++) begin
			if (i % 300 == 0)
				base = ID_BITS'($urandom_range(0, 32'h7FFF_FF00));
			r = $urandom_range(0, 99);
			if (r < 5)
				id = ID_BITS'($urandom);
			else if (i % 300 < 150)
				id = ID_BITS'(base + ($urandom_range(0, 63) * 3));
			else
				id = ID_BITS'(base + $urandom_range(0, 200));
			r = $urandom_range(0, 99);
			if (i % 300 < 200)
				add_req(r < 60 ? ACT_INSERT :
					(r < 80 ? ACT_REMOVE : r < 95 ? ACT_QUERY : ACT_SPARE),
					id, i == 600);
			else
				add_req(r < 25 ? ACT_INSERT : (r < 85 ? ACT_REMOVE : ACT_QUERY), id);
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		while ((pending_reqs.size() != 0 || req.valid || expected_rsps.size() != 0) &&
				idle_cycles < STALL_LIMIT)
			@(posedge clk);
		if (idle_cycles >= STALL_LIMIT) begin
			$display("id_interval_set_table_core regression: fail");
			$finish;
		end else begin
			repeat (200) @(posedge clk);
			if (errors == 0 && expected_rsps.size() == 0)
				$display("id_interval_set_table_core regression: pass");
			else
				$display("id_interval_set_table_core regression: fail");
			$finish;
		end
	end

endmodule
